/* hdl/bfc_pkg.sv */
`default_nettype none

package bfc_pkg;

    // operation codes carried in each input word
    typedef enum logic [1:0] {
        OP_WRITE_KEY  = 2'd0,
        OP_LOAD_CHAIN = 2'd1,
        OP_ENCRYPT    = 2'd2,
        OP_DECRYPT    = 2'd3
    } t_opcode;

    // key store layout
    localparam int ROUNDS     = 'h10;
    localparam int P_WORDS    = 'h12;
    localparam int P_LAST     = 'h11;
    localparam int S0_BASE    = 'h12;
    localparam int S1_BASE    = 'h112;
    localparam int S2_BASE    = 'h212;
    localparam int S3_BASE    = 'h312;
    localparam int STORE_SIZE = 1042;

    localparam int IDX_W      = 11;
    localparam int P_IDX_W    = $clog2(P_WORDS);
    localparam int RND_W      = $clog2(ROUNDS);
    // each S-box memory holds two boxes of 256 words
    localparam int SMEM_DEPTH = 2 * (S1_BASE - S0_BASE);
    localparam int SMEM_AW    = $clog2(SMEM_DEPTH);

    typedef struct packed {
        t_opcode           opcode;
        logic [IDX_W-1:0]  word_index;
        logic [31:0]       word_value;
        logic [63:0]       block_in;
        logic              last_block;
    } t_in_word;

    typedef struct packed {
        logic [63:0] block_out;
        logic        last_out;
    } t_out_word;

endpackage

`default_nettype wire

/* hdl/blowfish_cbc_block_cipher.sv */
`default_nettype none

// Blowfish CBC block cipher, 64-bit blocks, first byte most significant.
// Input channel (i_in_valid / o_in_ready, i_in_word) takes one word per operation:
// key word write, chain load, encrypt or decrypt. Output channel (o_out_valid /
// i_out_ready, o_out_word) delivers one word per encrypt or decrypt only.
// Key writes and chain loads complete in the cycle they are accepted.
// A cipher block runs from acceptance to a valid output word in steps: for
// each round an issue step sends the four S-box reads to the two dual-read memories
// and a calc step combines the read data; after sixteen rounds a finish step does
// whitening and the CBC step. The next word is accepted the cycle after the
// result is registered, so no new word is taken while a block is in work.
// The result sits in an output register; the next block may run while it waits,
// but its own result is held back until the earlier word is taken.
// Reset (synchronous, active low) clears the chain value and the handshake
// state. The key store is not cleared and must be written before use.
module blowfish_cbc_block_cipher
    import bfc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_CALC,
        ST_FINISH
    } t_state;

    t_state             r_state;
    logic [RND_W-1:0]   r_round;
    logic               r_dir;
    logic [31:0]        r_left;
    logic [31:0]        r_right;
    logic [31:0]        r_t;
    logic [63:0]        r_chain;
    logic [63:0]        r_blk;
    logic               r_last;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic [31:0]        r_p [P_WORDS];
    logic [31:0]        r_mem_a [SMEM_DEPTH];
    logic [31:0]        r_mem_b [SMEM_DEPTH];
    logic [31:0]        r_rd_s0, r_rd_s1, r_rd_s2, r_rd_s3;

    logic               accept;
    logic               key_we;
    logic               p_we;
    logic               s_we;
    logic [IDX_W-1:0]   key_off;
    logic [P_IDX_W-1:0] p_idx;
    logic [31:0]        t_cur;
    logic [31:0]        f_out;
    logic [63:0]        x_in;
    logic [63:0]        cipher_out;
    logic [63:0]        n_result;
    logic [63:0]        n_chain;
    logic               out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign out_free    = !r_out_valid || i_out_ready;

    // key store write decode
    assign key_we  = accept && (i_in_word.opcode == OP_WRITE_KEY);
    assign key_off = i_in_word.word_index - IDX_W'(S0_BASE);
    assign p_we    = key_we && (i_in_word.word_index < IDX_W'(P_WORDS));
    assign s_we    = key_we && (i_in_word.word_index >= IDX_W'(S0_BASE))
                     && (i_in_word.word_index < IDX_W'(STORE_SIZE));

    // P word for this round: forward order to encrypt, reverse to decrypt
    assign p_idx = r_dir ? (P_IDX_W'(P_LAST) - P_IDX_W'(r_round))
                         : P_IDX_W'(r_round);
    assign t_cur = r_left ^ r_p[p_idx];

    // round function on the registered S-box reads
    assign f_out = ((r_rd_s0 + r_rd_s1) ^ r_rd_s2) + r_rd_s3;

    // CBC input side: encrypt folds the chain in before the rounds
    assign x_in = (i_in_word.opcode == OP_ENCRYPT) ? (i_in_word.block_in ^ r_chain)
                                                   : i_in_word.block_in;

    // final whitening and CBC output side
    always_comb begin
        if (r_dir) begin
            cipher_out = {r_p[0] ^ r_right, r_p[1] ^ r_left};
            n_result   = cipher_out ^ r_chain;
            n_chain    = r_blk;
        end else begin
            cipher_out = {r_p[P_LAST] ^ r_right, r_p[ROUNDS] ^ r_left};
            n_result   = cipher_out;
            n_chain    = cipher_out;
        end
    end

    // P array registers
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_p[i_in_word.word_index[P_IDX_W-1:0]] <= i_in_word.word_value;
        end
    end

    // S0/S1 memory; writes only happen while idle, so no overlap with round reads
    always_ff @(posedge i_clk) begin
        if (s_we && !key_off[SMEM_AW]) begin
            r_mem_a[key_off[SMEM_AW-1:0]] <= i_in_word.word_value;
        end
        r_rd_s0 <= r_mem_a[{1'b0, t_cur[31:24]}];
        r_rd_s1 <= r_mem_a[{1'b1, t_cur[23:16]}];
    end

    // S2/S3 memory
    always_ff @(posedge i_clk) begin
        if (s_we && key_off[SMEM_AW]) begin
            r_mem_b[key_off[SMEM_AW-1:0]] <= i_in_word.word_value;
        end
        r_rd_s2 <= r_mem_b[{1'b0, t_cur[15:8]}];
        r_rd_s3 <= r_mem_b[{1'b1, t_cur[7:0]}];
    end

    // sequencer, chain and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_chain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the finish step handles the output register itself
            if (r_out_valid && i_out_ready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_in_word.opcode)
                            OP_WRITE_KEY: begin
                            end
                            OP_LOAD_CHAIN: begin
                                r_chain <= i_in_word.block_in;
                            end
                            OP_ENCRYPT, OP_DECRYPT: begin
                                r_dir   <= (i_in_word.opcode == OP_DECRYPT);
                                r_left  <= x_in[63:32];
                                r_right <= x_in[31:0];
                                r_blk   <= i_in_word.block_in;
                                r_last  <= i_in_word.last_block;
                                r_round <= '0;
                                r_state <= ST_ISSUE;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ISSUE: begin
                    r_t     <= t_cur;
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    r_left  <= f_out ^ r_right;
                    r_right <= r_t;
                    r_round <= r_round + 1'b1;
                    r_state <= (r_round == RND_W'(ROUNDS - 1)) ? ST_FINISH : ST_ISSUE;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out_word.block_out <= n_result;
                        r_out_word.last_out  <= r_last;
                        r_out_valid          <= 1'b1;
                        r_chain              <= n_chain;
                        r_state              <= ST_IDLE;
                    end else begin
                        r_out_valid          <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
